### sv/pedal_torque_interpolator_macros.svh
// Assertion macros shared by the pedal torque interpolator modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef PEDAL_TORQUE_INTERPOLATOR_MACROS_SVH
`define PEDAL_TORQUE_INTERPOLATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTI_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pedal_torque_interpolator: implication failed");

// The consequent must hold in the cycle after the antecedent.
`define PTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pedal_torque_interpolator: next-cycle check failed");

`endif

### sv/pti_pkg.sv
// Shared types and constants of the pedal torque interpolator.
// Depends on nothing; used by every module of the block.
package pti_pkg;

	localparam int PEDAL_W        = 10;
	localparam int KOUT_W         = 15;
	localparam int TORQUE_W       = 16;
	localparam int KNOT_SLOTS     = 6;
	localparam int KNOTS_PER_WORD = 3;
	localparam int KIN_REG_W      = PEDAL_W * KNOT_SLOTS;
	localparam int KOUT_REG_W     = KOUT_W * KNOTS_PER_WORD;
	localparam int COUNT_W        = 3;
	localparam int QUO_W          = 15;
	localparam int PROD_W         = PEDAL_W + QUO_W;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = KIN_REG_W;
	localparam int LATENCY        = QUO_W + 3;

	localparam logic [CFG_IDX_W-1:0] REG_KNOT_INPUTS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KNOT_OUTPUTS_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KNOT_OUTPUTS_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KNOT_COUNT       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_DIRECTION   = 3'd4;

	localparam logic [KIN_REG_W-1:0]  KIN_RESET      = 60'h000_0000_3FF0_0000;
	localparam logic [KOUT_REG_W-1:0] KOUT_LOW_RESET = 45'h0000_3FFF_8000;
	localparam logic [COUNT_W-1:0]    COUNT_RESET    = 3'd2;

	typedef struct packed {
		logic [KIN_REG_W-1:0]  knot_inputs;
		logic [KOUT_REG_W-1:0] knot_outputs_low;
		logic [KOUT_REG_W-1:0] knot_outputs_high;
		logic [COUNT_W-1:0]    knot_count;
	} map_t;

	typedef struct packed {
		logic              valid;
		logic [PEDAL_W-1:0] rem;
		logic [QUO_W-1:0]   dvd;
		logic [QUO_W-1:0]   quo;
		logic [PEDAL_W-1:0] dvs;
		logic [KOUT_W-1:0]  base;
		logic              neg;
	} work_t;

endpackage

### sv/pti_select.sv
// Segment selection and product stage of the pedal torque interpolator.
// Depends on pti_pkg and the assertion macro header.
`include "pedal_torque_interpolator_macros.svh"

module pti_select #(
	parameter int MAX_KNOTS = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [pti_pkg::PEDAL_W-1:0] pedal,
	input  pti_pkg::map_t               map,
	output pti_pkg::work_t              work
);
	import pti_pkg::*;

	localparam int IDX_W = $clog2(MAX_KNOTS);

	logic [PEDAL_W-1:0]  kin  [MAX_KNOTS];
	logic [KOUT_W-1:0]   kout [MAX_KNOTS];
	logic [COUNT_W-1:0]  n_use;
	logic [IDX_W-1:0]    last_idx;
	logic [IDX_W-1:0]    seg;
	logic [IDX_W-1:0]    seg_lo;
	logic [PEDAL_W-1:0]  delta_d;
	logic [TORQUE_W-1:0] dout_d;
	logic [PEDAL_W-1:0]  din_d;
	logic [KOUT_W-1:0]   base_d;

	logic                valid_s1;
	logic [PEDAL_W-1:0]  delta_s1;
	logic [TORQUE_W-1:0] dout_s1;
	logic [PEDAL_W-1:0]  din_s1;
	logic [KOUT_W-1:0]   base_s1;

	logic [TORQUE_W-1:0] mag;
	logic [PROD_W-1:0]   prod;
	work_t               work_s2;

	for (genvar k = 0; k < MAX_KNOTS; k++) begin : g_knot
		assign kin[k] = map.knot_inputs[PEDAL_W*k +: PEDAL_W];
		if (k < KNOTS_PER_WORD) begin : g_low
			assign kout[k] = map.knot_outputs_low[KOUT_W*k +: KOUT_W];
		end else begin : g_high
			assign kout[k] = map.knot_outputs_high[KOUT_W*(k-KNOTS_PER_WORD) +: KOUT_W];
		end
	end

	always_comb begin
		if (map.knot_count < 3'd2) begin
			n_use = 3'd2;
		end else if (map.knot_count > COUNT_W'(MAX_KNOTS)) begin
			n_use = COUNT_W'(MAX_KNOTS);
		end else begin
			n_use = map.knot_count;
		end
	end

	assign last_idx = IDX_W'(n_use - 3'd1);

	// The lowest knot at or above the sample closes the segment.
	always_comb begin
		seg = IDX_W'(1);
		for (int i = MAX_KNOTS - 1; i >= 1; i--) begin
			if ((COUNT_W'(i) < n_use) && (pedal <= kin[i])) begin
				seg = IDX_W'(i);
			end
		end
	end

	assign seg_lo = seg - IDX_W'(1);

	always_comb begin
		delta_d = '0;
		dout_d  = '0;
		din_d   = PEDAL_W'(1);
		base_d  = '0;
		if (pedal <= kin[0]) begin
			base_d = '0;
		end else if (pedal >= kin[last_idx]) begin
			base_d = kout[last_idx];
		end else begin
			delta_d = pedal - kin[seg_lo];
			dout_d  = {1'b0, kout[seg]} - {1'b0, kout[seg_lo]};
			din_d   = kin[seg] - kin[seg_lo];
			base_d  = kout[seg_lo];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		delta_s1 <= delta_d;
		dout_s1  <= dout_d;
		din_s1   <= din_d;
		base_s1  <= base_d;
	end

	assign mag  = dout_s1[TORQUE_W-1] ? TORQUE_W'(-dout_s1) : dout_s1;
	assign prod = PROD_W'(delta_s1) * PROD_W'(mag[QUO_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_s2.valid <= 1'b0;
		end else begin
			work_s2.valid <= valid_s1;
			work_s2.rem   <= prod[PROD_W-1:QUO_W];
			work_s2.dvd   <= prod[QUO_W-1:0];
			work_s2.quo   <= '0;
			work_s2.dvs   <= din_s1;
			work_s2.base  <= base_s1;
			work_s2.neg   <= dout_s1[TORQUE_W-1];
		end
	end

	assign work = work_s2;

	`PTI_ASSERT_IMPLY(a_divisor_nonzero, clk, arst_n, valid_s1, din_s1 != '0)
	`PTI_ASSERT_IMPLY(a_quotient_fits, clk, arst_n, work_s2.valid, work_s2.rem < work_s2.dvs)

endmodule

### sv/pti_div_cell.sv
// One restoring division cell: brings down one dividend bit, yields one quotient bit.
// Depends on pti_pkg and the assertion macro header.
`include "pedal_torque_interpolator_macros.svh"

module pti_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  pti_pkg::work_t work_in,
	output pti_pkg::work_t work_out
);
	import pti_pkg::*;

	logic [PEDAL_W:0] trial;
	logic [PEDAL_W:0] diff;
	logic             fits;
	work_t            step_q;

	assign trial = {work_in.rem, work_in.dvd[QUO_W-1]};
	assign diff  = trial - {1'b0, work_in.dvs};
	assign fits  = trial >= {1'b0, work_in.dvs};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q.valid <= 1'b0;
		end else begin
			step_q.valid <= work_in.valid;
			step_q.rem   <= fits ? diff[PEDAL_W-1:0] : trial[PEDAL_W-1:0];
			step_q.dvd   <= {work_in.dvd[QUO_W-2:0], 1'b0};
			step_q.quo   <= {work_in.quo[QUO_W-2:0], fits};
			step_q.dvs   <= work_in.dvs;
			step_q.base  <= work_in.base;
			step_q.neg   <= work_in.neg;
		end
	end

	assign work_out = step_q;

	`PTI_ASSERT_NEXT(a_valid_moves, clk, arst_n, work_in.valid, step_q.valid)
	`PTI_ASSERT_IMPLY(a_rem_below_dvs, clk, arst_n, step_q.valid, step_q.rem < step_q.dvs)

endmodule

### sv/pedal_torque_interpolator.sv
// Pedal torque interpolator: configuration registers, division chain and result stage.
// Depends on pti_pkg, pti_select, pti_div_cell and the assertion macro header.
//
// Each pedal sample requested with start yields exactly one torque command on
// torque_command, marked by a one-cycle done strobe. busy is always low, so a new
// sample may be requested in every cycle. Each request passes through the segment
// selection stage, the multiply stage, the chain of 15 division cells, one
// quotient bit each, and the result register, in that order.
// Results cannot be held off by the receiver. cfg_ready is always high; write the
// map only when no sample is in flight.
`include "pedal_torque_interpolator_macros.svh"

module pedal_torque_interpolator #(
	parameter int MAX_KNOTS = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [pti_pkg::PEDAL_W-1:0]         pedal_position,
	output logic                                done,
	output logic signed [pti_pkg::TORQUE_W-1:0] torque_command,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pti_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pti_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import pti_pkg::*;

	logic [KIN_REG_W-1:0]  knot_inputs_q;
	logic [KOUT_REG_W-1:0] knot_outputs_low_q;
	logic [KOUT_REG_W-1:0] knot_outputs_high_q;
	logic [COUNT_W-1:0]    knot_count_q;
	logic                  flip_q;
	map_t                  map;
	logic                  accept;
	work_t                 chain [QUO_W+1];
	work_t                 last;
	logic [TORQUE_W-1:0]   quo_ext;
	logic [TORQUE_W-1:0]   offs;
	logic [TORQUE_W-1:0]   sum;
	logic                  done_q;
	logic [TORQUE_W-1:0]   torque_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knot_inputs_q       <= KIN_RESET;
			knot_outputs_low_q  <= KOUT_LOW_RESET;
			knot_outputs_high_q <= '0;
			knot_count_q        <= COUNT_RESET;
			flip_q              <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KNOT_INPUTS: begin
					knot_inputs_q <= cfg_data[KIN_REG_W-1:0];
				end
				REG_KNOT_OUTPUTS_LOW: begin
					knot_outputs_low_q <= cfg_data[KOUT_REG_W-1:0];
				end
				REG_KNOT_OUTPUTS_HIGH: begin
					knot_outputs_high_q <= cfg_data[KOUT_REG_W-1:0];
				end
				REG_KNOT_COUNT: begin
					knot_count_q <= cfg_data[COUNT_W-1:0];
				end
				REG_FLIP_DIRECTION: begin
					flip_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign map.knot_inputs       = knot_inputs_q;
	assign map.knot_outputs_low  = knot_outputs_low_q;
	assign map.knot_outputs_high = knot_outputs_high_q;
	assign map.knot_count        = knot_count_q;

	pti_select #(
		.MAX_KNOTS(MAX_KNOTS)
	) u_select (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.pedal (pedal_position),
		.map   (map),
		.work  (chain[0])
	);

	for (genvar c = 0; c < QUO_W; c++) begin : g_div
		pti_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.work_in (chain[c]),
			.work_out(chain[c+1])
		);
	end

	assign last    = chain[QUO_W];
	assign quo_ext = {1'b0, last.quo};
	assign offs    = last.neg ? TORQUE_W'(-quo_ext) : quo_ext;
	assign sum     = {1'b0, last.base} + offs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		torque_q <= flip_q ? TORQUE_W'(-sum) : sum;
	end

	assign done           = done_q;
	assign torque_command = torque_q;

	`PTI_ASSERT_IMPLY(a_done_follows_request, clk, arst_n, done, $past(accept, LATENCY))

endmodule
